/* rtl/srtf_pkg.sv */
// Shared constants, types and encodings for the SRTF burst scheduler.
package srtf_pkg;

    localparam int TASK_COUNT = 5;
    localparam int BURST_BITS = 8;
    localparam int CNT_W      = BURST_BITS + 3;
    localparam int IDX_W      = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;
    localparam int SLOT_W     = 3;
    localparam int FIELD_W    = 8;
    localparam int RUN_W      = 3;
    localparam int MASK_W     = 5;
    localparam int CMP_W      = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef enum logic [1:0] {
        ST_EMPTY = 2'd0,
        ST_READY = 2'd1,
        ST_IO    = 2'd2,
        ST_DONE  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_SCAN   = 2'd1,
        S_UPDATE = 2'd2,
        S_REPORT = 2'd3
    } t_state;

    typedef struct packed {
        logic [BURST_BITS-1:0] cpu1;
        logic [BURST_BITS-1:0] cpu2;
        logic [BURST_BITS-1:0] cpu3;
        logic [BURST_BITS-1:0] io1;
        logic [BURST_BITS-1:0] io2;
        logic [BURST_BITS-1:0] io3;
    } t_bursts;

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] idx;
        logic [CNT_W-1:0] rem;
    } t_tok;

    typedef struct packed {
        logic              load;
        logic [SLOT_W-1:0] slot;
        logic              upd;
        logic              sel_valid;
        logic [IDX_W-1:0]  sel_idx;
    } t_ctl;

endpackage

/* rtl/srtf_burst_scheduler.sv */
// Top level: command sequencer, row of task cells and status mask collection.
// A load beat returns its result in the cycle after acceptance; busy is high for 1 cycle.
// A tick beat returns its result once the selection token has walked the row of cells,
// one cell per cycle, followed by the update state and then the report state.
// One beat at a time; the result strobe lasts one cycle and cannot be stalled.
// Synchronous active-low reset empties every task and clears every count.
module srtf_burst_scheduler (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_opcode,
    input  logic [srtf_pkg::SLOT_W-1:0] i_task_slot,
    input  logic [srtf_pkg::FIELD_W-1:0] i_cpu_first,
    input  logic [srtf_pkg::FIELD_W-1:0] i_cpu_second,
    input  logic [srtf_pkg::FIELD_W-1:0] i_cpu_third,
    input  logic [srtf_pkg::FIELD_W-1:0] i_io_first,
    input  logic [srtf_pkg::FIELD_W-1:0] i_io_second,
    input  logic [srtf_pkg::FIELD_W-1:0] i_io_third,
    output logic                        o_result_valid,
    output logic [srtf_pkg::RUN_W-1:0]  o_running_task,
    output logic [srtf_pkg::MASK_W-1:0] o_ready_mask,
    output logic [srtf_pkg::MASK_W-1:0] o_io_mask,
    output logic [srtf_pkg::MASK_W-1:0] o_finished_mask,
    output logic                        o_all_done
);

    srtf_pkg::t_state             r_state, n_state;
    logic [srtf_pkg::IDX_W-1:0]   r_cnt, n_cnt;
    logic [srtf_pkg::RUN_W-1:0]   r_running, n_running;

    srtf_pkg::t_ctl     ctl;
    srtf_pkg::t_bursts  bursts;
    srtf_pkg::t_tok     tok [srtf_pkg::TASK_COUNT+1];
    srtf_pkg::t_status  status [srtf_pkg::TASK_COUNT];
    logic               accept;

    assign accept = start && (r_state == srtf_pkg::S_IDLE);

    assign bursts.cpu1 = srtf_pkg::BURST_BITS'(i_cpu_first);
    assign bursts.cpu2 = srtf_pkg::BURST_BITS'(i_cpu_second);
    assign bursts.cpu3 = srtf_pkg::BURST_BITS'(i_cpu_third);
    assign bursts.io1  = srtf_pkg::BURST_BITS'(i_io_first);
    assign bursts.io2  = srtf_pkg::BURST_BITS'(i_io_second);
    assign bursts.io3  = srtf_pkg::BURST_BITS'(i_io_third);

    assign tok[0] = '0;

    for (genvar g = 0; g < srtf_pkg::TASK_COUNT; g++) begin : g_cell
        srtf_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_idx    (srtf_pkg::IDX_W'(g)),
            .i_ctl    (ctl),
            .i_bursts (bursts),
            .i_tok    (tok[g]),
            .o_tok    (tok[g+1]),
            .o_status (status[g])
        );
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            srtf_pkg::S_IDLE: begin
                if (start) begin
                    n_state = (i_opcode == srtf_pkg::OP_TICK) ? srtf_pkg::S_SCAN
                                                              : srtf_pkg::S_REPORT;
                end
            end
            srtf_pkg::S_SCAN: begin
                if (r_cnt == srtf_pkg::IDX_W'(srtf_pkg::TASK_COUNT - 1)) begin
                    n_state = srtf_pkg::S_UPDATE;
                end
            end
            srtf_pkg::S_UPDATE: n_state = srtf_pkg::S_REPORT;
            srtf_pkg::S_REPORT: n_state = srtf_pkg::S_IDLE;
            default:            n_state = srtf_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_cnt     = r_cnt;
        n_running = r_running;
        if (r_state == srtf_pkg::S_IDLE) begin
            n_cnt = '0;
            if (start) begin
                n_running = '0;
            end
        end else if (r_state == srtf_pkg::S_SCAN) begin
            n_cnt = r_cnt + 1'b1;
        end else if (r_state == srtf_pkg::S_UPDATE) begin
            n_running = tok[srtf_pkg::TASK_COUNT].valid ?
                        srtf_pkg::RUN_W'(int'(tok[srtf_pkg::TASK_COUNT].idx) + 1) : '0;
        end
    end

    always_comb begin
        busy           = (r_state != srtf_pkg::S_IDLE);
        o_result_valid = (r_state == srtf_pkg::S_REPORT);
        ctl.load       = accept && (i_opcode == srtf_pkg::OP_LOAD) &&
                         (int'(i_task_slot) < srtf_pkg::TASK_COUNT);
        ctl.slot       = i_task_slot;
        ctl.upd        = (r_state == srtf_pkg::S_UPDATE);
        ctl.sel_valid  = tok[srtf_pkg::TASK_COUNT].valid;
        ctl.sel_idx    = tok[srtf_pkg::TASK_COUNT].idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= srtf_pkg::S_IDLE;
            r_cnt     <= '0;
            r_running <= '0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_running <= n_running;
        end
    end

    always_comb begin
        logic loaded;
        logic active;
        loaded          = 1'b0;
        active          = 1'b0;
        o_ready_mask    = '0;
        o_io_mask       = '0;
        o_finished_mask = '0;
        for (int i = 0; i < srtf_pkg::TASK_COUNT; i++) begin
            if (status[i] != srtf_pkg::ST_EMPTY) begin
                loaded = 1'b1;
            end
            if (status[i] == srtf_pkg::ST_READY || status[i] == srtf_pkg::ST_IO) begin
                active = 1'b1;
            end
            if (i < srtf_pkg::MASK_W) begin
                o_ready_mask[i]    = (status[i] == srtf_pkg::ST_READY);
                o_io_mask[i]       = (status[i] == srtf_pkg::ST_IO);
                o_finished_mask[i] = (status[i] == srtf_pkg::ST_DONE);
            end
        end
        o_all_done = loaded && !active;
    end

    assign o_running_task = r_running;

endmodule

/* rtl/srtf_cell.sv */
// One task cell: holds a task's bounds, count and status, passes the selection token on.
module srtf_cell (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [srtf_pkg::IDX_W-1:0] i_idx,
    input  srtf_pkg::t_ctl          i_ctl,
    input  srtf_pkg::t_bursts       i_bursts,
    input  srtf_pkg::t_tok          i_tok,
    output srtf_pkg::t_tok          o_tok,
    output srtf_pkg::t_status       o_status
);

    logic [srtf_pkg::CNT_W-1:0] r_b1, r_b2, r_b3, r_t1, r_t12, r_tot;
    logic [srtf_pkg::CNT_W-1:0] r_count, n_count;
    srtf_pkg::t_status          r_status, n_status;
    srtf_pkg::t_tok             r_tok, n_tok;

    logic [srtf_pkg::CNT_W-1:0] l_b1, l_t1, l_b2, l_t12, l_b3, l_tot;
    logic [srtf_pkg::CNT_W-1:0] rem;
    logic [srtf_pkg::CNT_W-1:0] e_end, f_end, c1, c2;
    logic                       load_hit, run_hit;

    assign load_hit = i_ctl.load &&
                      (srtf_pkg::CMP_W'(i_ctl.slot) == srtf_pkg::CMP_W'(i_idx));
    assign run_hit  = i_ctl.upd && i_ctl.sel_valid && (i_ctl.sel_idx == i_idx);

    assign l_b1  = srtf_pkg::CNT_W'(i_bursts.cpu1);
    assign l_t1  = l_b1  + srtf_pkg::CNT_W'(i_bursts.io1);
    assign l_b2  = l_t1  + srtf_pkg::CNT_W'(i_bursts.cpu2);
    assign l_t12 = l_b2  + srtf_pkg::CNT_W'(i_bursts.io2);
    assign l_b3  = l_t12 + srtf_pkg::CNT_W'(i_bursts.cpu3);
    assign l_tot = l_b3  + srtf_pkg::CNT_W'(i_bursts.io3);

    assign rem = r_tot - r_count;
    assign c1  = r_count + srtf_pkg::CNT_W'(1);
    assign c2  = r_count + srtf_pkg::CNT_W'(2);

    always_comb begin
        priority if (r_count < r_b1) begin
            e_end = r_b1;
        end else if (r_count < r_b2) begin
            e_end = r_b2;
        end else begin
            e_end = r_b3;
        end
        priority if (r_count < r_b2) begin
            f_end = r_t1;
        end else if (r_count < r_b3) begin
            f_end = r_t12;
        end else begin
            f_end = r_tot;
        end
    end

    always_comb begin
        n_count  = r_count;
        n_status = r_status;
        priority if (load_hit) begin
            n_count  = '0;
            n_status = srtf_pkg::ST_READY;
        end else if (run_hit) begin
            n_count  = (c1 >= e_end) ? c1 : c2;
            n_status = (n_count >= e_end) ? srtf_pkg::ST_IO : srtf_pkg::ST_READY;
        end else if (i_ctl.upd && r_status == srtf_pkg::ST_IO) begin
            priority if (c1 >= f_end) begin
                n_count  = c1;
                n_status = (c1 < r_b3) ? srtf_pkg::ST_READY : srtf_pkg::ST_DONE;
            end else if (c2 >= f_end) begin
                n_count  = c2;
                n_status = (c2 < r_b3) ? srtf_pkg::ST_READY : srtf_pkg::ST_DONE;
            end else begin
                n_count  = c2;
            end
        end
    end

    always_comb begin
        n_tok = i_tok;
        if (r_status == srtf_pkg::ST_READY && (!i_tok.valid || rem < i_tok.rem)) begin
            n_tok.valid = 1'b1;
            n_tok.idx   = i_idx;
            n_tok.rem   = rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status <= srtf_pkg::ST_EMPTY;
            r_count  <= '0;
            r_tok    <= '0;
        end else begin
            r_status <= n_status;
            r_count  <= n_count;
            r_tok    <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_hit) begin
            r_b1  <= l_b1;
            r_t1  <= l_t1;
            r_b2  <= l_b2;
            r_t12 <= l_t12;
            r_b3  <= l_b3;
            r_tot <= l_tot;
        end
    end

    assign o_tok    = r_tok;
    assign o_status = r_status;

endmodule
